@@ design/rtc_pkg.sv @@
// Package for the real-time clock and calendar: opcodes, limits, state type and helpers.
`timescale 1ns / 1ps

package rtc_pkg;

   typedef enum logic [3:0] {
      OP_TICK   = 4'd0,
      OP_MODE   = 4'd1,
      OP_AMPM   = 4'd2,
      OP_YEAR   = 4'd3,
      OP_MONTH  = 4'd4,
      OP_DAY    = 4'd5,
      OP_HOUR   = 4'd6,
      OP_MINUTE = 4'd7,
      OP_SECOND = 4'd8
   } opcode_type;

   localparam int unsigned VALUE_W = 14;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned SEC_W   = 6;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned REQ_USER_W = 4;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned RSP_USED_W = 42;

   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
   localparam logic [SEC_W-1:0]   SIXTY_M1  = 6'd59;

   localparam logic [YEAR_W-1:0]  RST_YEAR   = 14'd2022;
   localparam logic [MONTH_W-1:0] RST_MONTH  = 4'd12;
   localparam logic [DAY_W-1:0]   RST_DAY    = 5'd31;
   localparam logic [HOUR_W-1:0]  RST_HOUR   = 5'd11;
   localparam logic [MIN_W-1:0]   RST_MINUTE = 6'd59;
   localparam logic [SEC_W-1:0]   RST_SECOND = 6'd47;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
      logic               twelve_hour;
      logic               morning;
   } cal_type;

   // Days in a month; February gets 29 when the year is a multiple of four.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic [YEAR_W-1:0]  year);
      logic [DAY_W-1:0] days;
      unique case (month)
         4'd2:                      days = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

   function automatic logic [VALUE_W-1:0] clamp(input logic [VALUE_W-1:0] v,
                                                 input logic [VALUE_W-1:0] lo,
                                                 input logic [VALUE_W-1:0] hi);
      logic [VALUE_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ design/rtc_calendar_12_24.sv @@
// Real-time clock and calendar with 12/24-hour modes, one command beat in, one snapshot out.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake           | Payload
// req      | in  | req_tvalid/tready   | tuser: opcode[3:0]; tdata: load_value[13:0], 2 pad
// rsp      | out | rsp_tvalid/tready   | tdata: year, month, day, hour, minute, second,
//          |     |                     |        twelve_hour, is_morning, 6 pad bits
//
// One command beat per cycle sustained while rsp is not stalled; an accepted beat fills the
// input register, then the calendar and result register, where it raises rsp_tvalid.
// The result register frees for the next beat in the same cycle its beat is taken, so a
// stalled rsp holds one beat in each register before req_tready drops.
// Synchronous active-high reset loads 2022-12-31 11:59:47 in 24-hour mode, AM set,
// and empties both registers.

module rtc_calendar_12_24 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rtc_pkg::REQ_DATA_W-1:0]        req_tdata,  // [13:0] load_value, [15:14] 0
   input  logic [rtc_pkg::REQ_USER_W-1:0]        req_tuser,  // [3:0] opcode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
   // [39:34] second, [40] twelve_hour, [41] is_morning, [47:42] 0
   output logic [rtc_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   // input register
   logic                               in_valid_ff, in_valid_in;
   rtc_pkg::opcode_type                in_op_ff;
   logic [rtc_pkg::VALUE_W-1:0]        in_value_ff;

   // calendar state and result register
   rtc_pkg::cal_type                   cal_ff, cal_in;
   logic                               out_valid_ff, out_valid_in;
   logic [rtc_pkg::RSP_DATA_W-1:0]     out_data_ff, out_data_in;

   logic                               advance;
   logic                               is_morning;

   // tick scratch, one bit wider where the carry can overshoot
   logic [rtc_pkg::DAY_W:0]            day_t;
   logic [rtc_pkg::HOUR_W:0]           hour_t;
   logic [rtc_pkg::MONTH_W:0]          month_t;
   logic [rtc_pkg::DAY_W-1:0]          days_now;

   // Beat in the input register moves on when the result register is free or draining.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   assign days_now = rtc_pkg::month_days(cal_ff.month, cal_ff.year);

   always_comb begin
      cal_in  = cal_ff;
      day_t   = {1'b0, cal_ff.day};
      hour_t  = {1'b0, cal_ff.hour};
      month_t = {1'b0, cal_ff.month};
      unique case (in_op_ff)
         rtc_pkg::OP_TICK: begin
            if (cal_ff.second >= rtc_pkg::SIXTY_M1) begin
               cal_in.second = '0;
               if (cal_ff.minute >= rtc_pkg::SIXTY_M1) begin
                  cal_in.minute = '0;
                  hour_t = hour_t + 6'd1;
                  if (cal_ff.twelve_hour) begin
                     if (hour_t == 6'd12) begin
                        cal_in.morning = !cal_ff.morning;
                        // new day at midnight, i.e. the flip into AM
                        if (!cal_ff.morning) begin
                           day_t = day_t + 6'd1;
                        end
                     end
                     if (hour_t >= 6'd13) begin
                        hour_t = 6'd1;
                     end
                  end else if (hour_t >= 6'd24) begin
                     hour_t = '0;
                     day_t  = day_t + 6'd1;
                  end
               end else begin
                  cal_in.minute = cal_ff.minute + 6'd1;
               end
            end else begin
               cal_in.second = cal_ff.second + 6'd1;
            end
            cal_in.hour = hour_t[rtc_pkg::HOUR_W-1:0];
            // a day past month end (also one left by a month or year load) rolls over
            if (day_t > {1'b0, days_now}) begin
               day_t   = 6'd1;
               month_t = month_t + 5'd1;
               if (month_t > {1'b0, rtc_pkg::MONTH_MAX}) begin
                  month_t = 5'd1;
                  cal_in.year = (cal_ff.year >= rtc_pkg::YEAR_MAX) ? '0 :
                                cal_ff.year + 14'd1;
               end
            end
            cal_in.day   = day_t[rtc_pkg::DAY_W-1:0];
            cal_in.month = month_t[rtc_pkg::MONTH_W-1:0];
         end
         rtc_pkg::OP_MODE: begin
            if (cal_ff.twelve_hour) begin
               cal_in.twelve_hour = 1'b0;
               if (!cal_ff.morning && cal_ff.hour < 5'd12) begin
                  cal_in.hour = cal_ff.hour + 5'd12;
               end else if (cal_ff.morning && cal_ff.hour == 5'd12) begin
                  cal_in.hour = '0;
               end
            end else begin
               cal_in.twelve_hour = 1'b1;
               if (cal_ff.hour == 5'd0) begin
                  cal_in.morning = 1'b1;
                  cal_in.hour    = 5'd12;
               end else if (cal_ff.hour >= 5'd13) begin
                  cal_in.morning = 1'b0;
                  cal_in.hour    = cal_ff.hour - 5'd12;
               end else begin
                  cal_in.morning = (cal_ff.hour < 5'd12);
               end
            end
         end
         rtc_pkg::OP_AMPM: begin
            if (cal_ff.twelve_hour) begin
               cal_in.morning = !cal_ff.morning;
            end
         end
         rtc_pkg::OP_YEAR: begin
            cal_in.year = rtc_pkg::clamp(in_value_ff, 14'd0, rtc_pkg::YEAR_MAX);
         end
         rtc_pkg::OP_MONTH: begin
            cal_in.month = 4'(rtc_pkg::clamp(in_value_ff, 14'd1, 14'd12));
         end
         rtc_pkg::OP_DAY: begin
            cal_in.day = 5'(rtc_pkg::clamp(in_value_ff, 14'd1, {9'd0, days_now}));
         end
         rtc_pkg::OP_HOUR: begin
            cal_in.hour = cal_ff.twelve_hour ?
                          5'(rtc_pkg::clamp(in_value_ff, 14'd1, 14'd12)) :
                          5'(rtc_pkg::clamp(in_value_ff, 14'd0, 14'd23));
         end
         rtc_pkg::OP_MINUTE: begin
            cal_in.minute = 6'(rtc_pkg::clamp(in_value_ff, 14'd0, 14'd59));
         end
         rtc_pkg::OP_SECOND: begin
            cal_in.second = 6'(rtc_pkg::clamp(in_value_ff, 14'd0, 14'd59));
         end
         default: begin
         end
      endcase
   end

   // in 24-hour mode the AM bit follows the hour
   assign is_morning = cal_in.twelve_hour ? cal_in.morning : (cal_in.hour < 5'd12);

   assign out_data_in = {{(rtc_pkg::RSP_DATA_W - rtc_pkg::RSP_USED_W){1'b0}},
                         is_morning, cal_in.twelve_hour, cal_in.second, cal_in.minute,
                         cal_in.hour, cal_in.day, cal_in.month, cal_in.year};

   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cal_ff <= '{year: rtc_pkg::RST_YEAR, month: rtc_pkg::RST_MONTH,
                     day: rtc_pkg::RST_DAY, hour: rtc_pkg::RST_HOUR,
                     minute: rtc_pkg::RST_MINUTE, second: rtc_pkg::RST_SECOND,
                     twelve_hour: 1'b0, morning: 1'b1};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            cal_ff <= cal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= rtc_pkg::opcode_type'(req_tuser);
         in_value_ff <= req_tdata[rtc_pkg::VALUE_W-1:0];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ design/rtc_checker.sv @@
// Port-level checks for the clock/calendar, bound to the top level.
`timescale 1ns / 1ps

module rtc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rtc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_fields_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:0] <= 14'd9999 && rsp_tdata[17:14] >= 4'd1 &&
                     rsp_tdata[17:14] <= 4'd12 && rsp_tdata[22:18] >= 5'd1 &&
                     rsp_tdata[33:28] <= 6'd59 && rsp_tdata[39:34] <= 6'd59 &&
                     rsp_tdata[47:42] == 6'd0)
      else $error("calendar field out of range");

   a_hour_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[40] && rsp_tdata[27:23] >= 5'd1 &&
                      rsp_tdata[27:23] <= 5'd12) ||
                     (!rsp_tdata[40] && rsp_tdata[27:23] <= 5'd23))
      else $error("hour does not fit the mode");

   a_am_24h: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[40] |-> rsp_tdata[41] == (rsp_tdata[27:23] < 5'd12))
      else $error("AM bit disagrees with 24-hour hour");

endmodule

bind rtc_calendar_12_24 rtc_checker u_rtc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ test/rtc_calendar_12_24_tb.sv @@
// Self-checking testbench for the 12/24-hour real-time clock and calendar.
`timescale 1ns / 1ps

module rtc_calendar_12_24_tb;

   typedef logic [rtc_pkg::VALUE_W-1:0] value_type;

   // Calendar tracker: follows every accepted command beat, keeps the snapshots
   // still owed by the block, and compares each returned beat with the oldest one.
   class cal_scoreboard;
      int unsigned      year_now, month_now, day_now, hour_now, min_now, sec_now;
      bit               twelve_now, am_now;
      rtc_pkg::cal_type owed[$];
      int               checked;
      int               errors;

      function new();
         year_now   = 32'(rtc_pkg::RST_YEAR);
         month_now  = 32'(rtc_pkg::RST_MONTH);
         day_now    = 32'(rtc_pkg::RST_DAY);
         hour_now   = 32'(rtc_pkg::RST_HOUR);
         min_now    = 32'(rtc_pkg::RST_MINUTE);
         sec_now    = 32'(rtc_pkg::RST_SECOND);
         twelve_now = 1'b0;
         am_now     = 1'b1;
         checked    = 0;
         errors     = 0;
      endfunction

      function int unsigned days_in(int unsigned m, int unsigned y);
         case (m)
            2:             return (y % 4 == 0) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;   // also covers an out-of-range month
         endcase
      endfunction

      function int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // One-second tick with all the carries.
      function void one_second();
         sec_now++;
         if (sec_now >= 60) begin
            sec_now = 0;
            min_now++;
            if (min_now >= 60) begin
               min_now = 0;
               hour_now++;
               if (twelve_now) begin
                  if (hour_now == 12) begin
                     am_now = ~am_now;
                     if (am_now) day_now++;   // 11 PM -> 12 AM moves the date
                  end
                  if (hour_now >= 13) hour_now = 1;
               end else if (hour_now >= 24) begin
                  hour_now = 0;
                  day_now++;
               end
            end
         end
         // a day past month end (after a tick or a month/year load) rolls here
         if (day_now > days_in(month_now, year_now)) begin
            day_now = 1;
            month_now++;
            if (month_now > 12) begin
               month_now = 1;
               year_now  = (year_now >= 9999) ? 0 : year_now + 1;
            end
         end
      endfunction

      function void flip_mode();
         if (twelve_now) begin
            twelve_now = 1'b0;
            if (!am_now && hour_now < 12) hour_now += 12;
            else if (am_now && hour_now == 12) hour_now = 0;
         end else begin
            twelve_now = 1'b1;
            if (hour_now == 0) begin
               am_now   = 1'b1;
               hour_now = 12;
            end else if (hour_now >= 13) begin
               am_now   = 1'b0;
               hour_now -= 12;
            end else begin
               am_now = (hour_now < 12);
            end
         end
      endfunction

      function void note_input(logic [3:0] op, value_type v);
         int unsigned      val;
         rtc_pkg::cal_type snap;
         val = 32'(v);
         case (op)
            rtc_pkg::OP_TICK:   one_second();
            rtc_pkg::OP_MODE:   flip_mode();
            rtc_pkg::OP_AMPM:   if (twelve_now) am_now = ~am_now;
            rtc_pkg::OP_YEAR:   year_now  = bound(val, 0, 9999);
            rtc_pkg::OP_MONTH:  month_now = bound(val, 1, 12);
            rtc_pkg::OP_DAY:    day_now   = bound(val, 1, days_in(month_now, year_now));
            rtc_pkg::OP_HOUR:   hour_now  = twelve_now ? bound(val, 1, 12) : bound(val, 0, 23);
            rtc_pkg::OP_MINUTE: min_now   = bound(val, 0, 59);
            rtc_pkg::OP_SECOND: sec_now   = bound(val, 0, 59);
            default:            ;
         endcase
         snap.year        = year_now[rtc_pkg::YEAR_W-1:0];
         snap.month       = month_now[rtc_pkg::MONTH_W-1:0];
         snap.day         = day_now[rtc_pkg::DAY_W-1:0];
         snap.hour        = hour_now[rtc_pkg::HOUR_W-1:0];
         snap.minute      = min_now[rtc_pkg::MIN_W-1:0];
         snap.second      = sec_now[rtc_pkg::SEC_W-1:0];
         snap.twelve_hour = twelve_now;
         snap.morning     = twelve_now ? am_now : (hour_now < 12);
         owed.push_back(snap);
      endfunction

      function string show(rtc_pkg::cal_type c);
         return $sformatf("%0d-%0d-%0d %0d:%0d:%0d 12h=%0d am=%0d", c.year, c.month,
                          c.day, c.hour, c.minute, c.second, c.twelve_hour, c.morning);
      endfunction

      function void check_result(logic [rtc_pkg::RSP_DATA_W-1:0] d);
         rtc_pkg::cal_type got, want;
         got.year        = d[13:0];
         got.month       = d[17:14];
         got.day         = d[22:18];
         got.hour        = d[27:23];
         got.minute      = d[33:28];
         got.second      = d[39:34];
         got.twelve_hour = d[40];
         got.morning     = d[41];
         checked++;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("MISMATCH: result beat with nothing owed, tdata=%h", d);
            return;
         end
         want = owed.pop_front();
         if (got != want || d[rtc_pkg::RSP_DATA_W-1:rtc_pkg::RSP_USED_W] != '0) begin
            errors++;
            if (errors <= 10)
               $display("MISMATCH beat %0d: exp %s, got %s pad=%h", checked, show(want),
                        show(got), d[rtc_pkg::RSP_DATA_W-1:rtc_pkg::RSP_USED_W]);
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rtc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // [13:0] load_value, [15:14] 0
   logic [rtc_pkg::REQ_USER_W-1:0] req_tuser  = '0;   // [3:0] opcode
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
   // [39:34] second, [40] twelve_hour, [41] is_morning, [47:42] 0
   logic [rtc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   cal_scoreboard sb = new();

   // per-side run of zero-gap beats still to go: 0 = sender, 1 = receiver
   int calm_left[2] = '{0, 0};
   // set by the receiver during its long hold-off so the sender keeps pushing
   bit hold_off = 1'b0;

   int n_tick, n_mode, n_ampm, n_load, n_unused;

   rtc_calendar_12_24 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle cycles before the next beat; now and then a stretch with no idling.
   function automatic int pick_gap(input int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_left[side] = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   // Offer one command beat and hold it until the block takes it.
   // tvalid stays high across back-to-back beats, so it is only lowered for a gap.
   task automatic send_cmd(input logic [3:0] op, input int unsigned v);
      int        gap;
      value_type vb;
      vb  = value_type'(v);
      gap = hold_off ? 0 : pick_gap(0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(rtc_pkg::REQ_DATA_W-rtc_pkg::VALUE_W){1'b0}}, vb};
      do @(posedge clock); while (!req_tready);
      sb.note_input(op, vb);
      case (op)
         rtc_pkg::OP_TICK:  n_tick++;
         rtc_pkg::OP_MODE:  n_mode++;
         rtc_pkg::OP_AMPM:  n_ampm++;
         rtc_pkg::OP_YEAR, rtc_pkg::OP_MONTH, rtc_pkg::OP_DAY,
         rtc_pkg::OP_HOUR, rtc_pkg::OP_MINUTE, rtc_pkg::OP_SECOND: n_load++;
         default:  n_unused++;
      endcase
   endtask

   // Hour value biased to the points where modes and carries meet.
   function automatic int unsigned edge_hour();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 11;
         2:       return 12;
         3:       return 13;
         4:       return 23;
         default: return $urandom_range(0, 9999);
      endcase
   endfunction

   // One random command, values leaning on limits and rollover points.
   task automatic rand_cmd();
      int          r;
      logic [3:0]  op;
      int unsigned v;
      r = $urandom_range(0, 99);
      v = $urandom_range(0, 9999);
      if (r < 45)      op = rtc_pkg::OP_TICK;
      else if (r < 52) op = rtc_pkg::OP_MODE;
      else if (r < 58) op = rtc_pkg::OP_AMPM;
      else if (r < 62) op = 4'($urandom_range(int'(rtc_pkg::OP_SECOND) + 1,
                                             (1 << rtc_pkg::REQ_USER_W) - 1));
      else             op = 4'($urandom_range(int'(rtc_pkg::OP_YEAR),
                                             int'(rtc_pkg::OP_SECOND)));
      r = $urandom_range(0, 3);
      case (op)
         rtc_pkg::OP_YEAR:   if (r == 0) v = 9999;
                             else if (r == 1) v = $urandom_range(0, 2499) * 4;   // leap
                             else if (r == 2) v = $urandom_range(9990, 9999);
         rtc_pkg::OP_MONTH:  if (r == 0) v = 2;
                             else if (r == 1) v = 12;
                             else if (r == 2) v = $urandom_range(0, 15);
         rtc_pkg::OP_DAY:    if (r < 2) v = $urandom_range(28, 31);
                             else if (r == 2) v = $urandom_range(0, 1);
         rtc_pkg::OP_HOUR:   if (r < 3) v = edge_hour();
         rtc_pkg::OP_MINUTE, rtc_pkg::OP_SECOND:
                             if (r < 2) v = $urandom_range(57, 59);
                             else if (r == 2) v = $urandom_range(0, 63);
         default:   ;
      endcase
      send_cmd(op, v);
   endtask

   // Receiver: random stalls, one long hold-off to back the block up.
   initial begin
      int gap;
      bit pressed;
      pressed = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!pressed && sb.checked >= 150) begin
            pressed  = 1'b1;
            hold_off = 1'b1;
            gap      = 120;
         end else begin
            gap = pick_gap(1);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         hold_off = 1'b0;
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   // Stimulus and end of run.
   initial begin
      int sent;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: rollover into noon, mode and AM/PM flips, year-end carry,
      // year wrap past 9999, leap February, clamps, unused opcodes.
      send_cmd(rtc_pkg::OP_TICK, 0);
      send_cmd(rtc_pkg::OP_SECOND, 9999);          // clamps to 59
      send_cmd(rtc_pkg::OP_TICK, 8191);            // 11:59:59 -> 12:00:00
      send_cmd(rtc_pkg::OP_MODE, 0);               // 12 PM
      send_cmd(rtc_pkg::OP_AMPM, 0);               // 12 AM
      send_cmd(rtc_pkg::OP_MODE, 0);               // back to 24h, hour 0
      send_cmd(rtc_pkg::OP_AMPM, 16383);           // ignored in 24h mode
      send_cmd(rtc_pkg::OP_HOUR, 23);
      send_cmd(rtc_pkg::OP_MINUTE, 59);
      send_cmd(rtc_pkg::OP_SECOND, 59);
      send_cmd(rtc_pkg::OP_TICK, 0);               // Dec 31 -> Jan 1 2023
      send_cmd(rtc_pkg::OP_YEAR, 9999);
      send_cmd(rtc_pkg::OP_MONTH, 12);
      send_cmd(rtc_pkg::OP_DAY, 31);
      send_cmd(rtc_pkg::OP_HOUR, 23);
      send_cmd(rtc_pkg::OP_MINUTE, 9999);
      send_cmd(rtc_pkg::OP_SECOND, 59);
      send_cmd(rtc_pkg::OP_TICK, 0);               // year wraps to 0
      send_cmd(rtc_pkg::OP_MONTH, 2);
      send_cmd(rtc_pkg::OP_DAY, 31);               // clamps to 29 in a leap year
      send_cmd(rtc_pkg::OP_YEAR, 1);               // day 29 now past the end of February
      send_cmd(rtc_pkg::OP_TICK, 0);               // moves to March 1
      send_cmd(rtc_pkg::OP_MONTH, 0);              // clamps to 1
      send_cmd(rtc_pkg::OP_HOUR, 0);
      send_cmd(rtc_pkg::OP_MODE, 0);               // 12 AM
      send_cmd(rtc_pkg::OP_HOUR, 0);               // clamps to 1 in 12h mode
      send_cmd(4'hF, 9999);                        // unused opcode

      // Random: mostly single commands, some end-of-hour/day setups with ticks.
      sent = 0;
      while (sent < 1350) begin
         if ($urandom_range(0, 99) < 8) begin
            if ($urandom_range(0, 1) == 1)
               send_cmd(rtc_pkg::OP_MONTH,
                        ($urandom_range(0, 1) == 1) ? 2 : $urandom_range(1, 12));
            send_cmd(rtc_pkg::OP_DAY, $urandom_range(28, 31));
            send_cmd(rtc_pkg::OP_HOUR, edge_hour());
            send_cmd(rtc_pkg::OP_MINUTE, 59);
            send_cmd(rtc_pkg::OP_SECOND, $urandom_range(57, 59));
            repeat (3) send_cmd(rtc_pkg::OP_TICK, $urandom_range(0, 9999));
            sent += 7;
         end else begin
            rand_cmd();
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (sb.owed.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);     // catch any stray beat past the last one

      $display("covered %0d beats: %0d ticks, %0d mode flips, %0d am/pm flips,",
               n_tick + n_mode + n_ampm + n_load + n_unused, n_tick, n_mode, n_ampm);
      $display("  %0d loads, %0d unused; %0d snapshots compared, %0d mismatches",
               n_load, n_unused, sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("rtc_calendar_12_24_tb: done, clean");
      end else begin
         $display("rtc_calendar_12_24_tb: done, errors");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout: %0d snapshots still owed", sb.owed.size());
      $display("rtc_calendar_12_24_tb: done, errors");
      $finish;
   end

endmodule
